[design/brl_pkg.sv]
// ----------------------------------------------------------------------------
// brl_pkg - shared types for the line rasterizer
// Coordinate width, the walker's state record and the pixel beat.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int unsigned CoordBits = 12;
  // error term spans about -2*delta .. 2*delta, plus sign
  localparam int unsigned ErrBits   = CoordBits + 3;

  localparam logic ActStart   = 1'b0;
  localparam logic ActAdvance = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [CoordBits:0]   dstep_t;

  typedef struct packed {
    logic                       active;
    coord_t                     cur_x;
    coord_t                     cur_y;
    coord_t                     major_end;
    logic                       major_is_y;
    logic                       step_down;
    dstep_t                     offset_step;
    dstep_t                     threshold_step;
    logic signed [ErrBits-1:0]  err;
  } line_state_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

endpackage

[design/brl_step.sv]
// ----------------------------------------------------------------------------
// brl_step - one rasterizer step
// Sets up a new line or walks the current one by one pixel; purely
// combinational, sits between the state register and the result register.
// ----------------------------------------------------------------------------
module brl_step (
  input  logic                 action_i,
  input  brl_pkg::coord_t      start_x_i,
  input  brl_pkg::coord_t      start_y_i,
  input  brl_pkg::coord_t      end_x_i,
  input  brl_pkg::coord_t      end_y_i,
  input  brl_pkg::line_state_t state_i,
  output brl_pkg::line_state_t state_o,
  output brl_pkg::pixel_t      pixel_o
);

  brl_pkg::coord_t adx, ady;
  logic            x_major, swap;
  brl_pkg::coord_t sx1, sy1, sx2, sy2;
  logic signed [brl_pkg::ErrBits-1:0] err_sum;
  logic            minor_step;
  brl_pkg::coord_t minor_cur, minor_nxt, major_nxt;
  brl_pkg::line_state_t nxt;
  brl_pkg::coord_t major_now;

  // setup path
  assign adx = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign ady = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
  assign x_major = (adx != '0) && (ady <= adx);
  assign swap = x_major ? (start_x_i > end_x_i) : (start_y_i > end_y_i);
  assign sx1 = swap ? end_x_i   : start_x_i;
  assign sy1 = swap ? end_y_i   : start_y_i;
  assign sx2 = swap ? start_x_i : end_x_i;
  assign sy2 = swap ? start_y_i : end_y_i;

  // walk path
  assign err_sum = state_i.err + $signed({2'b00, state_i.offset_step});
  assign minor_step = ~err_sum[brl_pkg::ErrBits-1];
  assign minor_cur = state_i.major_is_y ? state_i.cur_x : state_i.cur_y;
  assign minor_nxt = !minor_step ? minor_cur :
                     state_i.step_down ? minor_cur - 1'b1 : minor_cur + 1'b1;
  assign major_nxt = (state_i.major_is_y ? state_i.cur_y : state_i.cur_x) + 1'b1;

  always_comb begin
    nxt = state_i;
    if (action_i == brl_pkg::ActStart) begin
      nxt.major_is_y     = ~x_major;
      nxt.major_end      = x_major ? sx2 : sy2;
      nxt.step_down      = x_major ? (sy2 < sy1) : (sx2 < sx1);
      nxt.offset_step    = x_major ? {ady, 1'b0} : {adx, 1'b0};
      nxt.threshold_step = x_major ? {adx, 1'b0} : {ady, 1'b0};
      nxt.err            = -$signed({3'b000, (x_major ? adx : ady)});
      nxt.cur_x          = sx1;
      nxt.cur_y          = sy1;
    end else begin
      nxt.err = minor_step ? err_sum - $signed({2'b00, state_i.threshold_step})
                           : err_sum;
      if (state_i.major_is_y) begin
        nxt.cur_y = major_nxt;
        nxt.cur_x = minor_nxt;
      end else begin
        nxt.cur_x = major_nxt;
        nxt.cur_y = minor_nxt;
      end
    end
  end

  assign major_now = nxt.major_is_y ? nxt.cur_y : nxt.cur_x;

  always_comb begin
    state_o = nxt;
    pixel_o = '{valid: 1'b1, x: nxt.cur_x, y: nxt.cur_y,
                last: (major_now == nxt.major_end)};
    state_o.active = (major_now != nxt.major_end);
    // advance with nothing to walk: empty beat, state untouched
    if (action_i == brl_pkg::ActAdvance && !state_i.active) begin
      state_o = state_i;
      pixel_o = '0;
    end
  end

endmodule

[design/bresenham_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer - integer line rasterizer
// Start beats load two endpoints, advance beats walk the line pixel by pixel.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one pixel beat, in the cycle after it is taken.
// The walker does one add, one compare and one subtract per pixel between the
// line state register and the output register, so a beat can be taken in
// every cycle: one pixel per clock while the output side is not stalled. The
// input is stalled only while a pixel sits in the output register and the
// output side stalls it. A start beat gives the first pixel; an advance beat
// with no line active gives a beat with pixel_valid low and all fields zero.
module bresenham_line_rasterizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            action_i,
  input  brl_pkg::coord_t start_x_i,
  input  brl_pkg::coord_t start_y_i,
  input  brl_pkg::coord_t end_x_i,
  input  brl_pkg::coord_t end_y_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            pixel_valid_o,
  output brl_pkg::coord_t pixel_x_o,
  output brl_pkg::coord_t pixel_y_o,
  output logic            last_pixel_o
);

  brl_pkg::line_state_t state_q, state_d;
  brl_pkg::pixel_t      pixel_q, pixel_d;
  logic                 out_valid_q;
  logic                 in_accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  brl_step u_step (
    .action_i  (action_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .state_i   (state_q),
    .state_o   (state_d),
    .pixel_o   (pixel_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = pixel_q.valid;
  assign pixel_x_o     = pixel_q.x;
  assign pixel_y_o     = pixel_q.y;
  assign last_pixel_o  = pixel_q.last;

endmodule

[design/brl_checker.sv]
// ----------------------------------------------------------------------------
// brl_checker - port level checks for the line rasterizer
// Watches the top level ports; attached with a bind below.
// ----------------------------------------------------------------------------
module brl_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            pixel_valid_o,
  input brl_pkg::coord_t pixel_x_o,
  input brl_pkg::coord_t pixel_y_o,
  input logic            last_pixel_o
);

  // every taken beat shows up at the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat gave no pixel beat");

  // an empty output register never back-pressures the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // no-line beat carries only zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |-> pixel_x_o == '0 && pixel_y_o == '0 && !last_pixel_o)
    else $error("empty pixel beat has nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o)
      && $stable(pixel_valid_o) && $stable(last_pixel_o))
    else $error("stalled pixel beat changed");

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_valid_o (pixel_valid_o),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .last_pixel_o  (last_pixel_o)
);
